// File: hdl/assert_macros.svh
// Concurrent assertion helpers, clocked on clk and quiet during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define COT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cigar text assertion failed");

// Next-cycle implication.
`define COT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cigar text assertion failed");

`endif

// File: hdl/cot_pkg.sv
package cot_pkg;

  localparam int LEN_W       = 28;
  localparam int BCD_DIGITS  = 9;
  localparam int BCD_W       = 4 * BCD_DIGITS;
  localparam int CNT_W       = $clog2(LEN_W);
  localparam int DIG_W       = $clog2(BCD_DIGITS);
  localparam int POS_W       = 16;
  localparam int TEXT_MARGIN = 11;
  localparam logic [POS_W-1:0] BUF_SIZE_RESET = 16'd1024;

  localparam int         NUM_OP_CHARS = 9;
  localparam logic [3:0] OP_CODE_MAX  = 4'd8;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NUL     = 8'h00;

  localparam logic [7:0] OP_CHARS [NUM_OP_CHARS] =
    '{8'h4d, 8'h49, 8'h44, 8'h4e, 8'h53, 8'h48, 8'h50, 8'h3d, 8'h58};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT,
    ST_CHR,
    ST_TERM
  } cot_state_t;

  function automatic logic [7:0] op_char(input logic [3:0] code);
    logic [7:0] ch;
    ch = CHAR_NUL;
    if (code <= OP_CODE_MAX) begin
      ch = OP_CHARS[code];
    end
    return ch;
  endfunction

endpackage

// File: hdl/cot_channels.sv
interface cot_op_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] op_word;

  modport source (output valid, output func, output op_word, input ready);
  modport sink   (input valid, input func, input op_word, output ready);
endinterface

interface cot_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  logic       complete;
  logic       bad_op;

  modport source (output valid, output out_char, output last, output complete,
                  output bad_op, input ready);
  modport sink   (input valid, input out_char, input last, input complete,
                  input bad_op, output ready);
endinterface

interface cot_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] buffer_size;

  modport source (output valid, output buffer_size, input ready);
  modport sink   (input valid, input buffer_size, output ready);
endinterface

// File: hdl/cigar_ops_to_text.sv
// cigar_ops_to_text: binary CIGAR op words in, SAM-style CIGAR text out.
//
// op_in carries one word per op (func = 0) or an end-of-record mark
// (func = 1). txt_out carries one character per word: the decimal length
// without leading zeros, then the op letter (a zero character and bad_op
// for codes above 8), with last on the letter. End of record gives a zero
// terminator with last and complete (no op dropped), then clears the record.
// cfg writes buffer_size; an op is written only while the character count
// is below buffer_size minus 11, otherwise it is dropped silently.
//
// Sequence: ST_IDLE accepts one op, ST_CONV runs bit-serial binary-to-BCD
// conversion (one length bit per cycle), ST_EMIT gives the digits (one BCD
// digit per cycle while the output register is free, leading zeros skipped
// without output) and ST_CHR the letter. A dropped op stays in ST_IDLE; end
// of record goes through ST_TERM. One item is in work at a time.
// A one-word output register holds each character; when the receiver stalls
// the sequencer holds at its next character until the word is taken.
// Reset (rst, synchronous): buffer_size returns to 1024, the position and the
// dropped flag clear, the output register empties.
`include "assert_macros.svh"

module cigar_ops_to_text (
  input  logic clk,
  input  logic rst,
  cot_op_if.sink     op_in,
  cot_text_if.source txt_out,
  cot_cfg_if.sink    cfg
);
  import cot_pkg::*;

  cot_state_t state, state_next;

  // Conversion datapath
  logic [LEN_W-1:0] len_sr;
  logic [BCD_W-1:0] bcd;
  logic [BCD_W-1:0] bcd_adj;
  logic [CNT_W-1:0] cnt;
  logic [DIG_W-1:0] dig_left;
  logic             started;
  logic [3:0]       code;

  // Record state and configuration
  logic [POS_W-1:0] wp;
  logic             dropped;
  logic [POS_W-1:0] buf_size;

  // Output register
  logic       ov;
  logic [7:0] o_char;
  logic       o_last;
  logic       o_cmp;
  logic       o_bad;

  // Sequencer controls
  logic       slot_free;
  logic       fits;
  logic       take_op;
  logic       do_drop;
  logic       conv_step;
  logic       dig_shift;
  logic       emit;
  logic       clr_rec;
  logic [7:0] e_char;
  logic       e_last;
  logic       e_cmp;
  logic       skip;

  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    r = v;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (v[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = v[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  // Ready only between items; the register leaves room for the margin.
  assign op_in.ready = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;
  assign slot_free   = !ov || txt_out.ready;
  assign fits        = (buf_size > POS_W'(TEXT_MARGIN)) &&
                       (wp < buf_size - POS_W'(TEXT_MARGIN));
  assign skip        = !started && (bcd[BCD_W-1 -: 4] == 4'd0) && (dig_left != '0);
  assign bcd_adj     = bcd_adjust(bcd);

  always_comb begin
    state_next = state;
    take_op    = 1'b0;
    do_drop    = 1'b0;
    conv_step  = 1'b0;
    dig_shift  = 1'b0;
    emit       = 1'b0;
    clr_rec    = 1'b0;
    e_char     = CHAR_NUL;
    e_last     = 1'b0;
    e_cmp      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (op_in.valid) begin
          if (op_in.func) begin
            state_next = ST_TERM;
          end else if (fits) begin
            take_op    = 1'b1;
            state_next = ST_CONV;
          end else begin
            do_drop = 1'b1;
          end
        end
      end
      ST_CONV: begin
        conv_step = 1'b1;
        if (cnt == CNT_W'(LEN_W - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (skip) begin
          dig_shift = 1'b1;
        end else if (slot_free) begin
          dig_shift = 1'b1;
          emit      = 1'b1;
          e_char    = CHAR_ZERO + {4'd0, bcd[BCD_W-1 -: 4]};
          if (dig_left == '0) begin
            state_next = ST_CHR;
          end
        end
      end
      ST_CHR: begin
        if (slot_free) begin
          emit       = 1'b1;
          e_char     = op_char(code);
          e_last     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_TERM: begin
        if (slot_free) begin
          emit       = 1'b1;
          e_char     = CHAR_NUL;
          e_last     = 1'b1;
          e_cmp      = !dropped;
          clr_rec    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Record state and configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      dropped  <= 1'b0;
      buf_size <= BUF_SIZE_RESET;
    end else begin
      if (cfg.valid) begin
        buf_size <= cfg.buffer_size;
      end
      if (clr_rec) begin
        wp      <= '0;
        dropped <= 1'b0;
      end else begin
        if (emit) begin
          wp <= wp + POS_W'(1);
        end
        if (do_drop) begin
          dropped <= 1'b1;
        end
      end
    end
  end

  // Conversion and digit shift registers
  always_ff @(posedge clk) begin
    if (take_op) begin
      len_sr   <= op_in.op_word[31:4];
      code     <= op_in.op_word[3:0];
      bcd      <= '0;
      cnt      <= '0;
      dig_left <= DIG_W'(BCD_DIGITS - 1);
      started  <= 1'b0;
    end else if (conv_step) begin
      // add-3 correction, then shift in the next length bit, MSB first
      bcd    <= {bcd_adj[BCD_W-2:0], len_sr[LEN_W-1]};
      len_sr <= {len_sr[LEN_W-2:0], 1'b0};
      cnt    <= cnt + CNT_W'(1);
    end else if (dig_shift) begin
      bcd      <= {bcd[BCD_W-5:0], 4'd0};
      started  <= started | emit;
      if (dig_left != '0) begin
        dig_left <= dig_left - DIG_W'(1);
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (emit) begin
      ov <= 1'b1;
    end else if (txt_out.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_char <= e_char;
      o_last <= e_last;
      o_cmp  <= e_cmp;
      o_bad  <= (state != ST_TERM) && (code > OP_CODE_MAX);
    end
  end

  assign txt_out.valid    = ov;
  assign txt_out.out_char = o_char;
  assign txt_out.last     = o_last;
  assign txt_out.complete = o_cmp;
  assign txt_out.bad_op   = o_bad;

  `COT_ASSERT_NEXT(a_conv_to_emit, (state == ST_CONV) && (cnt == CNT_W'(LEN_W - 1)),
    state == ST_EMIT)
  `COT_ASSERT_NEXT(a_drop_marks, op_in.valid && op_in.ready && !op_in.func && !fits,
    dropped && (state == ST_IDLE))
  `COT_ASSERT_IMPL(a_complete_on_term, txt_out.valid && txt_out.complete,
    txt_out.last && (txt_out.out_char == CHAR_NUL) && !txt_out.bad_op)

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

// Checks the CIGAR text generator word by word against a behavioral predictor.
// Ops and end-of-record marks go in one at a time; every character that comes
// out is matched with the oldest predicted character.
module tb_top;

  // Item kinds on the op channel.
  localparam logic FUNC_OP  = 1'b0;
  localparam logic FUNC_END = 1'b1;

  // Highest op code that has a letter; anything above is a bad op.
  localparam logic [3:0] OP_CODE_LAST = 4'd8;
  // Room kept free at the tail of the buffer: nine digits, a letter, the NUL.
  localparam int TAIL_ROOM = 11;
  localparam logic [7:0] NUL_CHAR = 8'h00;
  localparam logic [7:0] ASCII_0  = 8'h30;
  localparam logic [15:0] BUF_SIZE_AT_RESET = 16'd1024;

  localparam logic [7:0] OP_LETTERS [9] =
    '{"M", "I", "D", "N", "S", "H", "P", "=", "X"};

  // Give the block time to settle before a register write, so a dropped op or
  // a terminator still in flight has finished.
  localparam int IDLE_SETTLE = 50;
  // Cycle limit for the watchdog on the whole run.
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_IDLE    = 13;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       complete;
    logic       bad;
  } text_word_t;

  logic clk = 1'b0;
  logic rst;

  cot_op_if   op_ch ();
  cot_text_if txt_ch ();
  cot_cfg_if  cfg_ch ();

  cigar_ops_to_text dut (
    .clk     (clk),
    .rst     (rst),
    .op_in   (op_ch),
    .txt_out (txt_ch),
    .cfg     (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: mirrors the record the block is building.
  logic [cot_pkg::POS_W-1:0] buf_size_cfg = BUF_SIZE_AT_RESET;
  logic [cot_pkg::POS_W-1:0] rec_pos      = '0;
  logic                      rec_dropped  = 1'b0;

  text_word_t expected_text_q [$];

  // Idle modes: when steady, that side never inserts wait cycles.
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  int errors        = 0;
  int items_sent    = 0;
  int words_checked = 0;
  int ops_written   = 0;
  int ops_dropped_n = 0;
  int bad_ops_n     = 0;
  int records_ended = 0;
  int cfg_writes    = 0;
  int cycles        = 0;

  // Add one predicted word at the tail of the queue.
  function automatic void queue_expected(input text_word_t e);
    expected_text_q.insert(expected_text_q.size(), e);
  endfunction

  // Work out the characters one item produces and queue them up; advance
  // the record state the same way the block must.
  function automatic void predict_cigar_text(input logic f, input logic [31:0] w);
    text_word_t  e;
    logic [27:0] len;
    logic [3:0]  code;
    logic        bad;
    logic [7:0]  digs [10];
    int          nd;

    nd = 0;
    if (f == FUNC_END) begin
      // Terminator always goes out, full buffer or not; then clear the record.
      e.ch       = NUL_CHAR;
      e.last     = 1'b1;
      e.complete = !rec_dropped;
      e.bad      = 1'b0;
      queue_expected(e);
      rec_pos     = '0;
      rec_dropped = 1'b0;
      records_ended++;
      return;
    end

    // Drop the op when it might not fit (covers buffers of 11 and below too).
    if (int'(buf_size_cfg) <= TAIL_ROOM || int'(rec_pos) >= int'(buf_size_cfg) - TAIL_ROOM)
    begin
      rec_dropped = 1'b1;
      ops_dropped_n++;
      return;
    end

    len  = w[31:4];
    code = w[3:0];
    bad  = (code > OP_CODE_LAST);
    if (bad) bad_ops_n++;

    // Peel off decimal digits, least significant first.
    do begin
      digs[nd] = ASCII_0 + 8'(len % 10);
      len      = len / 10;
      nd++;
    end while (len != 0);

    for (int i = nd - 1; i >= 0; i--) begin
      e.ch       = digs[i];
      e.last     = 1'b0;
      e.complete = 1'b0;
      e.bad      = bad;
      queue_expected(e);
    end
    e.ch       = bad ? NUL_CHAR : OP_LETTERS[code];
    e.last     = 1'b1;
    e.complete = 1'b0;
    e.bad      = bad;
    queue_expected(e);

    rec_pos = rec_pos + 16'(nd + 1);
    ops_written++;
  endfunction

  // Present one item and hold it until the block takes it. Valid is only
  // lowered when a gap is drawn, so back-to-back items keep it high.
  task automatic send_cigar_item(input logic f, input logic [31:0] w);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      op_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predict_cigar_text(f, w);
    op_ch.valid   <= 1'b1;
    op_ch.func    <= f;
    op_ch.op_word <= w;
    @(posedge clk);
    while (!op_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and hold until every predicted character has come out,
  // then let the block settle for a while.
  task automatic await_text_drain(input int settle);
    op_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_text_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write buffer_size with the block idle; the predictor follows on accept.
  task automatic write_buffer_size(input logic [15:0] v);
    await_text_drain(IDLE_SETTLE);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.buffer_size <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    buf_size_cfg = v;
    cfg_writes++;
  endtask

  function automatic void report_field(input string name, input logic [7:0] want_v,
                                       input logic [7:0] got_v);
    $display("[%0t] %s mismatch: expected 0x%02h, got 0x%02h", $time, name, want_v, got_v);
    errors++;
  endfunction

  task automatic check_text_word(input text_word_t got);
    text_word_t want;
    words_checked++;
    if (expected_text_q.size() == 0) begin
      $display("[%0t] unexpected word: expected none, got char 0x%02h last %0b",
               $time, got.ch, got.last);
      errors++;
    end else begin
      want = expected_text_q.pop_front();
      if (got.ch !== want.ch)             report_field("out_char", want.ch, got.ch);
      if (got.last !== want.last)         report_field("last", 8'(want.last), 8'(got.last));
      if (got.complete !== want.complete) report_field("complete", 8'(want.complete),
                                                       8'(got.complete));
      if (got.bad !== want.bad)           report_field("bad_op", 8'(want.bad), 8'(got.bad));
    end
  endtask

  // Text receiver: take a word on each handshake, then draw a stall before
  // raising ready again. One nonblocking write of ready per edge.
  initial begin
    int rx_wait;
    rx_wait = 0;
    txt_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        txt_ch.ready <= 1'b0;
      end else begin
        if (txt_ch.valid && txt_ch.ready) begin
          check_text_word({txt_ch.out_char, txt_ch.last, txt_ch.complete, txt_ch.bad_op});
          rx_wait = rx_steady ? 0 : $urandom_range(0, MAX_IDLE);
        end
        if (rx_wait > 0) begin
          txt_ch.ready <= 1'b0;
          rx_wait--;
        end else begin
          txt_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[%0t] run stuck: %0d words still outstanding", $time, expected_text_q.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Default buffer after reset: every op letter, digit-count edges, the
  // largest length, bad codes, and an end mark carrying junk in op_word.
  task automatic test_default_buffer();
    logic [27:0] lens [8];
    lens = '{28'd1, 28'd9, 28'd10, 28'd99, 28'd100, 28'd12345, 28'd99999999, 28'd100000000};
    send_cigar_item(FUNC_OP, 32'h0000_0000);
    for (int c = 1; c <= 8; c++) send_cigar_item(FUNC_OP, {lens[c-1], 4'(c)});
    send_cigar_item(FUNC_OP, 32'hFFFF_FFFF);
    send_cigar_item(FUNC_OP, {28'd7, 4'd9});
    send_cigar_item(FUNC_END, 32'hFFFF_FFFF);
  endtask

  // Buffer edges: the smallest buffer takes exactly one op, a tiny buffer
  // takes none, and the largest buffer takes the widest op.
  task automatic test_buffer_edges();
    write_buffer_size(16'd12);
    send_cigar_item(FUNC_OP, {28'd123, 4'd0});
    send_cigar_item(FUNC_OP, {28'd5, 4'd1});
    send_cigar_item(FUNC_END, 32'h0);
    send_cigar_item(FUNC_END, 32'h0);

    write_buffer_size(16'd11);
    send_cigar_item(FUNC_OP, {28'd1, 4'd2});
    send_cigar_item(FUNC_END, 32'h0);

    write_buffer_size(16'hFFFF);
    send_cigar_item(FUNC_OP, {28'hFFF_FFFF, 4'd8});
    send_cigar_item(FUNC_END, 32'h0);
  endtask

  // Random records over many buffer sizes. Small buffers dominate so that
  // records run into the full condition; ends come often enough that most
  // records also finish cleanly.
  task automatic test_random_records(input int target);
    int          first;
    int          sel;
    int          roll;
    int          phase_items;
    logic [15:0] bsz;
    logic [27:0] len;
    logic [3:0]  code;
    logic [31:0] w;

    first = items_sent;
    while (items_sent - first < target) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       bsz = 16'd12;
        1:       bsz = 16'hFFFF;
        2:       bsz = BUF_SIZE_AT_RESET;
        default: bsz = 16'($urandom_range(13, 90));
      endcase
      write_buffer_size(bsz);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);

      phase_items = $urandom_range(12, 40);
      repeat (phase_items) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          // Hold off until the text channel has caught up.
          await_text_drain(0);
        end else if (roll < 14) begin
          send_cigar_item(FUNC_END, $urandom());
        end else begin
          sel = $urandom_range(0, 5);
          case (sel)
            0:       len = 28'($urandom_range(0, 9));
            1:       len = 28'($urandom_range(10, 9999));
            2:       len = 28'($urandom_range(0, 999999));
            default: len = 28'($urandom());
          endcase
          code = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
          w = {len, code};
          if ($urandom_range(0, 7) == 0) w = $urandom();
          send_cigar_item(FUNC_OP, w);
        end
      end
    end
  endtask

  initial begin
    rst                <= 1'b1;
    op_ch.valid        <= 1'b0;
    op_ch.func         <= FUNC_OP;
    op_ch.op_word      <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.buffer_size <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_default_buffer();
    test_buffer_edges();
    test_random_records(450);

    // Drain: wait for the tail of the text, bounded, then look for leftovers.
    op_ch.valid <= 1'b0;
    for (int i = 0; i < 5000 && expected_text_q.size() != 0; i++) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
    if (expected_text_q.size() != 0) begin
      $display("[%0t] missing words: expected %0d more, got none",
               $time, expected_text_q.size());
      errors++;
    end

    $display("Ran %0d items (%0d ops written, %0d dropped, %0d bad codes, %0d records)",
             items_sent, ops_written, ops_dropped_n, bad_ops_n, records_ended);
    $display("Checked %0d text words across %0d buffer size writes, %0d mismatches",
             words_checked, cfg_writes, errors);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: cigar_ops_to_text.f
+incdir+hdl
hdl/cot_pkg.sv
hdl/cot_channels.sv
hdl/cigar_ops_to_text.sv
bench/tb_top.sv
